// ----- hw/rtl/pcgbr_pkg.sv -----
// ============================================================================
// pcgbr_pkg: shared types and constants for the bounded PCG32 generator
// Holds the LCG constants, register indexes, datapath command/status
// structs and the XSH-RR output permutation.
// ============================================================================
`default_nettype none

package pcgbr_pkg;

  localparam int WORD_W      = 32;
  localparam int STATE_W     = 64;
  localparam int STREAM_W    = 63;
  localparam int CFG_INDEX_W = 2;
  localparam int DIV_CNT_W   = $clog2(WORD_W);

  localparam logic [STATE_W-1:0] LCG_MULT  = 64'h5851_F42D_4C95_7F2D;
  localparam logic [STATE_W-1:0] GEN_RESET = 64'h853C_49E6_748F_EA9B;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SEED   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STREAM = 2'd1;

  // Operand pairing for the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } mul_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_load;
    logic     acc_add;
    logic     state_upd;
    logic     perm_load;
    logic     div_start;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic full_range;
    logic div_done;
    logic reject;
    logic out_free;
  } dp_status_t;

  // XSH-RR: xorshift high bits, then rotate right by the top five bits
  function automatic logic [WORD_W-1:0] permute(input logic [STATE_W-1:0] s);
    logic [STATE_W-1:0]   mixed;
    logic [WORD_W-1:0]    xs;
    logic [4:0]           rot;
    logic [2*WORD_W-1:0]  dbl;
    mixed = s ^ (s >> 18);
    xs    = mixed[58:27];
    rot   = s[63:59];
    dbl   = {xs, xs} >> rot;
    return dbl[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcgbr_div.sv -----
// ============================================================================
// pcgbr_div: iterative 32-bit remainder unit
// Restoring division, one quotient bit per cycle; only the remainder is kept.
// ============================================================================
`default_nettype none

module pcgbr_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [pcgbr_pkg::WORD_W-1:0] dividend,
  input  wire logic [pcgbr_pkg::WORD_W-1:0] divisor,
  output logic                             done,
  output logic [pcgbr_pkg::WORD_W-1:0]      remainder
);
  import pcgbr_pkg::*;

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(WORD_W - 1);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W-1:0]    dvd;
  logic [WORD_W-1:0]    dsr;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      rem_new;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    rem_sh  = {rem, dvd[WORD_W-1]};
    rem_new = (rem_sh >= {1'b0, dsr}) ? (rem_sh - {1'b0, dsr}) : rem_sh;
  end

  // Control: run one step per cycle, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_new[WORD_W-1:0];
      dvd <= {dvd[WORD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("remainder unit restarted while busy");
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    (done && (dsr != '0)) |-> (rem < dsr))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- hw/rtl/pcgbr_dp.sv -----
// ============================================================================
// pcgbr_dp: datapath for the bounded PCG32 generator
// Generator state, shared multiplier, output permutation, remainder unit,
// rejection test and the output register.
// ============================================================================
`default_nettype none

module pcgbr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pcgbr_pkg::dp_cmd_t                cmd,
  output pcgbr_pkg::dp_status_t                  status,
  input  wire logic                              cfg_we,
  input  wire logic [pcgbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pcgbr_pkg::STATE_W-1:0]     cfg_data,
  input  wire logic [pcgbr_pkg::WORD_W-1:0]      low_bound,
  input  wire logic [pcgbr_pkg::WORD_W-1:0]      high_bound,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [pcgbr_pkg::WORD_W-1:0]           value
);
  import pcgbr_pkg::*;

  logic [STATE_W-1:0]  gen_state;
  logic [STREAM_W-1:0] stream;
  logic [WORD_W-1:0]   lo;
  logic [WORD_W-1:0]   span;
  logic [WORD_W-1:0]   mul_a;
  logic [WORD_W-1:0]   mul_b;
  logic [STATE_W-1:0]  prod;
  logic [STATE_W-1:0]  acc;
  logic [WORD_W-1:0]   x;
  logic [WORD_W-1:0]   rem;
  logic                div_done;
  logic [WORD_W-1:0]   draw;

  // Select multiplier operands for the three partial products
  always_comb begin
    case (cmd.mul_sel)
      MUL_LL: begin
        mul_a = gen_state[WORD_W-1:0];
        mul_b = LCG_MULT[WORD_W-1:0];
      end
      MUL_HL: begin
        mul_a = gen_state[STATE_W-1:WORD_W];
        mul_b = LCG_MULT[WORD_W-1:0];
      end
      MUL_LH: begin
        mul_a = gen_state[WORD_W-1:0];
        mul_b = LCG_MULT[STATE_W-1:WORD_W];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Request capture, multiply, accumulate, permute
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      lo   <= low_bound;
      span <= high_bound - low_bound + 1'b1;
    end
    if (cmd.mul_en) begin
      prod <= {{WORD_W{1'b0}}, mul_a} * {{WORD_W{1'b0}}, mul_b};
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc[STATE_W-1:WORD_W] <= acc[STATE_W-1:WORD_W] + prod[WORD_W-1:0];
    end
    if (cmd.perm_load) begin
      x <= permute(gen_state);
    end
  end

  // Generator state and stream register; a seed write takes priority
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= GEN_RESET;
      stream    <= '0;
    end else begin
      if (cfg_we && (cfg_index == REG_SEED)) begin
        gen_state <= cfg_data;
      end else if (cmd.state_upd) begin
        gen_state <= acc + {stream, 1'b1};
      end
      if (cfg_we && (cfg_index == REG_STREAM)) begin
        stream <= cfg_data[STREAM_W-1:0];
      end
    end
  end

  pcgbr_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (x),
    .divisor   (span),
    .done      (div_done),
    .remainder (rem)
  );

  assign draw = (span == '0) ? x : rem;

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value <= lo + draw;
    end
  end

  always_comb begin
    status.full_range = (span == '0);
    status.div_done   = div_done;
    status.reject     = (x - rem) > ({WORD_W{1'b0}} - span);
    status.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/pcgbr_ctrl.sv -----
// ============================================================================
// pcgbr_ctrl: sequencer for the bounded PCG32 generator
// Steps the datapath through multiply, update, permute, remainder and the
// rejection test (skipped for a full range), redrawing until a draw is kept.
// ============================================================================
`default_nettype none

module pcgbr_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  req_valid,
  output logic                       req_stall,
  output pcgbr_pkg::dp_cmd_t         cmd,
  input  wire pcgbr_pkg::dp_status_t status
);
  import pcgbr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_UPD,
    S_PERM,
    S_DSTART,
    S_DIV,
    S_CHECK,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign req_stall = rst || (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    cmd.mul_sel = MUL_LL;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load_req = 1'b1;
          state_next   = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LL;
        state_next  = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_HL;
        cmd.acc_load = 1'b1;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_LH;
        cmd.acc_add = 1'b1;
        state_next  = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_add = 1'b1;
        state_next  = S_UPD;
      end
      S_UPD: begin
        cmd.state_upd = 1'b1;
        state_next    = S_PERM;
      end
      S_PERM: begin
        cmd.perm_load = 1'b1;
        state_next    = S_DSTART;
      end
      S_DSTART: begin
        if (status.full_range) begin
          state_next = S_FIN;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.reject ? S_MUL0 : S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MUL0))
    else $error("accepted item did not start a draw");
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    status.div_done |-> (state == S_DIV))
    else $error("remainder done outside divide wait");
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == S_FIN) && !status.out_free) |=> (state == S_FIN))
    else $error("result dropped while output register full");

endmodule

`default_nettype wire

// ----- hw/rtl/pcg32_bounded_random_top.sv -----
// ============================================================================
// pcg32_bounded_random_top: bounded uniform draws from a PCG32 generator
// One request [low_bound, high_bound] in, one value in that range out.
// ============================================================================
// Steps from accept to result valid when the first draw is kept: 4 multiply steps, update,
//   permute, remainder start, remainder wait, check, then the output load.
// A full range skips the remainder and check; a rejected draw restarts at the first multiply.
// A full output register holds the sequencer in its last step; requests stall until the load.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, rst high) loads the generator constant, zeroes the stream, empties output.
`default_nettype none

module pcg32_bounded_random_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              req_valid,
  output logic                                   req_stall,
  input  wire logic [pcgbr_pkg::WORD_W-1:0]      low_bound,
  input  wire logic [pcgbr_pkg::WORD_W-1:0]      high_bound,
  output logic                                   rsp_valid,
  input  wire logic                              rsp_stall,
  output logic [pcgbr_pkg::WORD_W-1:0]           value,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [pcgbr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pcgbr_pkg::STATE_W-1:0]     cfg_data
);
  import pcgbr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = !rst;

  pcgbr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .status    (status)
  );

  pcgbr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .low_bound  (low_bound),
    .high_bound (high_bound),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .value      (value)
  );

endmodule

`default_nettype wire
